>>> rtl/core/layout_command_lexer_unit_macros.svh
// ----------------------------------------------------------------------------
// layout command lexer assertion macros
// shared property forms for the lexer checks
// ----------------------------------------------------------------------------
`ifndef LAYOUT_COMMAND_LEXER_UNIT_MACROS_SVH
`define LAYOUT_COMMAND_LEXER_UNIT_MACROS_SVH

// same-cycle implication
`define LCL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// types, token and error codes and byte classes of the layout command lexer
// ----------------------------------------------------------------------------
`default_nettype none

package lcl_pkg;

   localparam int unsigned FIELD_POS_BITS = 16;

   // token kinds
   localparam logic [2:0] KIND_LPAREN = 3'd0;
   localparam logic [2:0] KIND_RPAREN = 3'd1;
   localparam logic [2:0] KIND_COMMA  = 3'd2;
   localparam logic [2:0] KIND_ARROW  = 3'd3;
   localparam logic [2:0] KIND_ONE    = 3'd4;
   localparam logic [2:0] KIND_SYMBOL = 3'd5;
   localparam logic [2:0] KIND_CLOSE  = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NONASCII  = 3'd1;
   localparam logic [2:0] ERR_LONE_MINUS = 3'd2;
   localparam logic [2:0] ERR_GT        = 3'd3;
   localparam logic [2:0] ERR_BAD_ONE   = 3'd4;
   localparam logic [2:0] ERR_DIGIT     = 3'd5;
   localparam logic [2:0] ERR_OTHER     = 3'd6;

   typedef enum logic [3:0] {
      CC_NONASCII,
      CC_SPACE,
      CC_LPAREN,
      CC_RPAREN,
      CC_COMMA,
      CC_MINUS,
      CC_GT,
      CC_ONE,
      CC_DIGIT,
      CC_LETTER,
      CC_UNDERSCORE,
      CC_OTHER
   } char_class_type;

   typedef struct packed {
      logic [2:0]                token_kind;
      logic [2:0]                error_code;
      logic [FIELD_POS_BITS-1:0] start_pos;
      logic [FIELD_POS_BITS-1:0] end_pos;
      logic                      last_result;
   } result_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      if (c[7]) begin
         cls = CC_NONASCII;
      end else begin
         case (c) inside
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: cls = CC_SPACE;
            8'h28:                                   cls = CC_LPAREN;
            8'h29:                                   cls = CC_RPAREN;
            8'h2C:                                   cls = CC_COMMA;
            8'h2D:                                   cls = CC_MINUS;
            8'h3E:                                   cls = CC_GT;
            8'h31:                                   cls = CC_ONE;
            [8'h30:8'h39]:                           cls = CC_DIGIT;
            [8'h41:8'h5A], [8'h61:8'h7A]:            cls = CC_LETTER;
            8'h5F:                                   cls = CC_UNDERSCORE;
            default:                                 cls = CC_OTHER;
         endcase
      end
      return cls;
   endfunction

   // bytes that may continue a symbol
   function automatic logic is_tail(input char_class_type cls);
      return (cls == CC_ONE) || (cls == CC_DIGIT) || (cls == CC_LETTER) ||
             (cls == CC_UNDERSCORE);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/layout_command_lexer_unit.sv
// Results are written to the four-entry result queue at the byte's transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
// rsp_ready stays high; the queue takes a byte only with room for three results.
// Reset (synchronous): mode idle, byte offset and token start zero, queue empty.
// ----------------------------------------------------------------------------
// layout_command_lexer_unit
// streaming lexer: one byte per transfer, up to three token/close results
// ----------------------------------------------------------------------------
`default_nettype none
`include "layout_command_lexer_unit_macros.svh"

module layout_command_lexer_unit #(
   parameter int unsigned POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_token_kind,
   output logic [2:0]       rsp_error_code,
   output logic [15:0]      rsp_start_pos,
   output logic [15:0]      rsp_end_pos,
   output logic             rsp_last_result
);

   localparam int unsigned DEPTH    = 4;
   localparam int unsigned MAX_RES  = 3;
   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_MINUS   = 3'd1;
   localparam logic [2:0] MODE_ONE     = 3'd2;
   localparam logic [2:0] MODE_SYMBOL  = 3'd3;
   localparam logic [2:0] MODE_DISCARD = 3'd4;

   logic [2:0]          mode_ff, mode_in;
   logic [POS_BITS-1:0] offset_ff, offset_in;
   logic [POS_BITS-1:0] start_ff, start_in;

   lcl_pkg::result_type fifo_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;

   lcl_pkg::result_type   res [MAX_RES];
   logic [1:0]            res_n;
   lcl_pkg::char_class_type cls;
   logic                  req_fire, rsp_fire;

   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] v,
                                                  input logic [1:0] d);
      logic [POS_BITS:0] s;
      s = {1'b0, v} + {{(POS_BITS - 1){1'b0}}, d};
      return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
   endfunction

   function automatic logic [15:0] to_field(input logic [POS_BITS-1:0] v);
      logic [POS_BITS+15:0] w;
      w = {16'b0, v};
      return w[15:0];
   endfunction

   function automatic lcl_pkg::result_type make_res(input logic [2:0] kind,
                                                   input logic [2:0] err,
                                                   input logic [POS_BITS-1:0] s,
                                                   input logic [POS_BITS-1:0] e,
                                                   input logic last);
      lcl_pkg::result_type r;
      r.token_kind  = kind;
      r.error_code  = err;
      r.start_pos   = to_field(s);
      r.end_pos     = to_field(e);
      r.last_result = last;
      return r;
   endfunction

   assign req_ready = (count_ff <= CNT_BITS'(DEPTH - MAX_RES));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign cls       = lcl_pkg::classify(req_char_code);

   // one byte of lexing: flush of a pending token, fresh lex, then close
   always_comb begin
      logic [2:0]          err;
      logic [POS_BITS-1:0] err_pos;
      logic [POS_BITS-1:0] p1;
      logic                fresh;
      err       = lcl_pkg::ERR_NONE;
      err_pos   = offset_ff;
      fresh     = 1'b0;
      p1        = sat_add(offset_ff, 2'd1);
      res_n     = 2'd0;
      mode_in   = mode_ff;
      offset_in = offset_ff;
      start_in  = start_ff;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = '0;
      end

      case (mode_ff)
         MODE_DISCARD: begin
         end
         MODE_MINUS: begin
            if (cls == lcl_pkg::CC_GT) begin
               res[res_n] = make_res(lcl_pkg::KIND_ARROW, lcl_pkg::ERR_NONE, start_ff,
                                     sat_add(start_ff, 2'd2), 1'b0);
               res_n   = res_n + 2'd1;
               mode_in = MODE_IDLE;
            end else begin
               err     = lcl_pkg::ERR_LONE_MINUS;
               err_pos = start_ff;
            end
         end
         MODE_ONE: begin
            if (cls == lcl_pkg::CC_NONASCII) begin
               err = lcl_pkg::ERR_NONASCII;
            end else if (lcl_pkg::is_tail(cls)) begin
               err     = lcl_pkg::ERR_BAD_ONE;
               err_pos = start_ff;
            end else begin
               res[res_n] = make_res(lcl_pkg::KIND_ONE, lcl_pkg::ERR_NONE, start_ff,
                                     sat_add(start_ff, 2'd1), 1'b0);
               res_n   = res_n + 2'd1;
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         end
         MODE_SYMBOL: begin
            if (cls == lcl_pkg::CC_NONASCII) begin
               err = lcl_pkg::ERR_NONASCII;
            end else if (!lcl_pkg::is_tail(cls)) begin
               res[res_n] = make_res(lcl_pkg::KIND_SYMBOL, lcl_pkg::ERR_NONE, start_ff,
                                     offset_ff, 1'b0);
               res_n   = res_n + 2'd1;
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            fresh   = 1'b1;
         end
      endcase

      if (fresh) begin
         case (cls)
            lcl_pkg::CC_NONASCII: err = lcl_pkg::ERR_NONASCII;
            lcl_pkg::CC_SPACE: begin
            end
            lcl_pkg::CC_LPAREN, lcl_pkg::CC_RPAREN, lcl_pkg::CC_COMMA: begin
               res[res_n] = make_res((cls == lcl_pkg::CC_LPAREN) ? lcl_pkg::KIND_LPAREN :
                                     (cls == lcl_pkg::CC_RPAREN) ? lcl_pkg::KIND_RPAREN :
                                     lcl_pkg::KIND_COMMA, lcl_pkg::ERR_NONE, offset_ff,
                                     p1, 1'b0);
               res_n = res_n + 2'd1;
            end
            lcl_pkg::CC_MINUS: begin
               mode_in  = MODE_MINUS;
               start_in = offset_ff;
            end
            lcl_pkg::CC_GT: err = lcl_pkg::ERR_GT;
            lcl_pkg::CC_ONE: begin
               mode_in  = MODE_ONE;
               start_in = offset_ff;
            end
            lcl_pkg::CC_DIGIT: err = lcl_pkg::ERR_DIGIT;
            lcl_pkg::CC_LETTER: begin
               mode_in  = MODE_SYMBOL;
               start_in = offset_ff;
            end
            default: err = lcl_pkg::ERR_OTHER;
         endcase
      end

      if (mode_ff == MODE_DISCARD) begin
         if (req_final_byte) begin
            mode_in   = MODE_IDLE;
            offset_in = '0;
            start_in  = '0;
         end
      end else if (err != lcl_pkg::ERR_NONE) begin
         res[res_n] = make_res(lcl_pkg::KIND_CLOSE, err, err_pos, '0, 1'b1);
         res_n = res_n + 2'd1;
         if (req_final_byte) begin
            mode_in   = MODE_IDLE;
            offset_in = '0;
            start_in  = '0;
         end else begin
            mode_in = MODE_DISCARD;
         end
      end else begin
         offset_in = p1;
         if (req_final_byte) begin
            if (mode_in == MODE_MINUS) begin
               res[res_n] = make_res(lcl_pkg::KIND_CLOSE, lcl_pkg::ERR_LONE_MINUS, start_in,
                                     '0, 1'b1);
               res_n = res_n + 2'd1;
            end else begin
               if (mode_in == MODE_ONE) begin
                  res[res_n] = make_res(lcl_pkg::KIND_ONE, lcl_pkg::ERR_NONE, start_in,
                                        sat_add(start_in, 2'd1), 1'b0);
                  res_n = res_n + 2'd1;
               end else if (mode_in == MODE_SYMBOL) begin
                  res[res_n] = make_res(lcl_pkg::KIND_SYMBOL, lcl_pkg::ERR_NONE, start_in,
                                        p1, 1'b0);
                  res_n = res_n + 2'd1;
               end
               res[res_n] = make_res(lcl_pkg::KIND_CLOSE, lcl_pkg::ERR_NONE, p1, p1, 1'b1);
               res_n = res_n + 2'd1;
            end
            mode_in   = MODE_IDLE;
            offset_in = '0;
            start_in  = '0;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = count_in + CNT_BITS'(res_n);
      end
      if (rsp_fire) begin
         count_in = count_in - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         start_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            mode_ff   <= mode_in;
            offset_ff <= offset_in;
            start_ff  <= start_in;
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(res_n);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < res_n) begin
               fifo_ff[wr_ptr_ff + PTR_BITS'(i)] <= res[i];
            end
         end
      end
   end

   assign rsp_token_kind  = fifo_ff[rd_ptr_ff].token_kind;
   assign rsp_error_code  = fifo_ff[rd_ptr_ff].error_code;
   assign rsp_start_pos   = fifo_ff[rd_ptr_ff].start_pos;
   assign rsp_end_pos     = fifo_ff[rd_ptr_ff].end_pos;
   assign rsp_last_result = fifo_ff[rd_ptr_ff].last_result;

   `LCL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH),
      "result queue overfilled")
   `LCL_ASSERT_SAME(a_last_is_close, clock, reset, rsp_valid,
      rsp_last_result == (rsp_token_kind == lcl_pkg::KIND_CLOSE),
      "last mark disagrees with close kind")
   `LCL_ASSERT_SAME(a_error_shape, clock, reset,
      rsp_valid && (rsp_error_code != lcl_pkg::ERR_NONE),
      rsp_last_result && (rsp_end_pos == 16'd0), "malformed error result")
   `LCL_ASSERT_NEXT(a_final_restarts, clock, reset, req_fire && req_final_byte,
      (mode_ff == MODE_IDLE) && (offset_ff == '0) && (start_ff == '0),
      "state not cleared after last byte")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// layout command lexer testbench
// streams command bytes into layout_command_lexer_unit with random gaps on
// both handshakes and checks every token and close result, field by field,
// against a behavioral lexer kept in a small scoreboard
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     POS_BITS       = 16;
   localparam longint unsigned POS_MAX        = (64'd1 << POS_BITS) - 64'd1;
   localparam int unsigned     MAX_GAP        = 19;
   localparam int unsigned     WATCHDOG_LIMIT = 2000;
   localparam int unsigned     DRAIN_CYCLES   = 32;
   localparam int unsigned     RANDOM_BYTES   = 72;

   typedef enum logic [2:0] {
      LEX_IDLE,
      LEX_MINUS,
      LEX_ONE,
      LEX_SYMBOL,
      LEX_DISCARD
   } lex_mode_type;

   class token_scoreboard;
      lcl_pkg::result_type expected_tokens[$];
      int unsigned         failures;
      lex_mode_type        mode;
      longint unsigned     next_offset;
      longint unsigned     token_begin;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         mode        = LEX_IDLE;
         next_offset = 0;
         token_begin = 0;
      endfunction

      function longint unsigned sat_inc(longint unsigned v, longint unsigned d);
         return (v + d > POS_MAX) ? POS_MAX : v + d;
      endfunction

      function logic is_space(logic [7:0] c);
         return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function logic is_letter(logic [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      function logic is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic continues_symbol(logic [7:0] c);
         return is_letter(c) || is_digit(c) || c == "_";
      endfunction

      function void expect_token(logic [2:0] kind, logic [2:0] err, longint unsigned s,
                                 longint unsigned e, logic last);
         lcl_pkg::result_type r;
         r.token_kind  = kind;
         r.error_code  = err;
         r.start_pos   = s[15:0];
         r.end_pos     = e[15:0];
         r.last_result = last;
         expected_tokens.push_back(r);
      endfunction

      // byte seen with nothing pending
      function logic [2:0] start_token(logic [7:0] c, longint unsigned p);
         if (c[7]) return lcl_pkg::ERR_NONASCII;
         if (is_space(c)) return lcl_pkg::ERR_NONE;
         case (c)
            "(": expect_token(lcl_pkg::KIND_LPAREN, lcl_pkg::ERR_NONE, p, sat_inc(p, 1), 1'b0);
            ")": expect_token(lcl_pkg::KIND_RPAREN, lcl_pkg::ERR_NONE, p, sat_inc(p, 1), 1'b0);
            ",": expect_token(lcl_pkg::KIND_COMMA, lcl_pkg::ERR_NONE, p, sat_inc(p, 1), 1'b0);
            ">": return lcl_pkg::ERR_GT;
            "-": begin
               mode        = LEX_MINUS;
               token_begin = p;
            end
            "1": begin
               mode        = LEX_ONE;
               token_begin = p;
            end
            default: begin
               if (is_digit(c)) return lcl_pkg::ERR_DIGIT;
               if (!is_letter(c)) return lcl_pkg::ERR_OTHER;
               mode        = LEX_SYMBOL;
               token_begin = p;
            end
         endcase
         return lcl_pkg::ERR_NONE;
      endfunction

      function void note_byte(logic [7:0] c, logic fin);
         longint unsigned p;
         longint unsigned err_pos;
         logic [2:0]      err;
         p       = next_offset;
         err_pos = p;
         err     = lcl_pkg::ERR_NONE;
         case (mode)
            LEX_DISCARD: begin
               if (fin) restart();
               return;
            end
            LEX_MINUS: begin
               if (c == ">") begin
                  expect_token(lcl_pkg::KIND_ARROW, lcl_pkg::ERR_NONE, token_begin,
                               sat_inc(token_begin, 2), 1'b0);
                  mode = LEX_IDLE;
               end else begin
                  err     = lcl_pkg::ERR_LONE_MINUS;
                  err_pos = token_begin;
               end
            end
            LEX_ONE: begin
               if (c[7]) begin
                  err = lcl_pkg::ERR_NONASCII;
               end else if (continues_symbol(c)) begin
                  err     = lcl_pkg::ERR_BAD_ONE;
                  err_pos = token_begin;
               end else begin
                  expect_token(lcl_pkg::KIND_ONE, lcl_pkg::ERR_NONE, token_begin,
                               sat_inc(token_begin, 1), 1'b0);
                  mode = LEX_IDLE;
                  err  = start_token(c, p);
               end
            end
            LEX_SYMBOL: begin
               if (c[7]) begin
                  err = lcl_pkg::ERR_NONASCII;
               end else if (!continues_symbol(c)) begin
                  expect_token(lcl_pkg::KIND_SYMBOL, lcl_pkg::ERR_NONE, token_begin, p, 1'b0);
                  mode = LEX_IDLE;
                  err  = start_token(c, p);
               end
            end
            default: begin
               mode = LEX_IDLE;
               err  = start_token(c, p);
            end
         endcase

         if (err != lcl_pkg::ERR_NONE) begin
            expect_token(lcl_pkg::KIND_CLOSE, err, err_pos, 0, 1'b1);
            if (fin) restart();
            else mode = LEX_DISCARD;
            return;
         end

         next_offset = sat_inc(p, 1);
         if (fin) begin
            if (mode == LEX_MINUS) begin
               expect_token(lcl_pkg::KIND_CLOSE, lcl_pkg::ERR_LONE_MINUS, token_begin, 0, 1'b1);
            end else begin
               if (mode == LEX_ONE)
                  expect_token(lcl_pkg::KIND_ONE, lcl_pkg::ERR_NONE, token_begin,
                               sat_inc(token_begin, 1), 1'b0);
               else if (mode == LEX_SYMBOL)
                  expect_token(lcl_pkg::KIND_SYMBOL, lcl_pkg::ERR_NONE, token_begin,
                               next_offset, 1'b0);
               expect_token(lcl_pkg::KIND_CLOSE, lcl_pkg::ERR_NONE, next_offset, next_offset,
                            1'b1);
            end
            restart();
         end
      endfunction

      function void compare_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_result(lcl_pkg::result_type got);
         lcl_pkg::result_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, actual kind %0d err %0d start %0d end %0d last %0d",
                     $time, got.token_kind, got.error_code, got.start_pos, got.end_pos,
                     got.last_result);
            failures++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.token_kind, got.token_kind);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("start_pos", want.start_pos, got.start_pos);
         compare_field("end_pos", want.end_pos, got.end_pos);
         compare_field("last_result", want.last_result, got.last_result);
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code  = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_start_pos;
   logic [15:0] rsp_end_pos;
   logic        rsp_last_result;

   logic        req_idle_on    = 1'b1;
   logic        rsp_idle_on    = 1'b1;
   int unsigned bytes_sent     = 0;
   int unsigned idle_cycles    = 0;
   logic [7:0]  cmd_bytes[$];

   token_scoreboard board = new();

   layout_command_lexer_unit #(
      .POS_BITS(POS_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_start_pos  (rsp_start_pos),
      .rsp_end_pos    (rsp_end_pos),
      .rsp_last_result(rsp_last_result)
   );

   always #4 clock = ~clock;

   // both channels observed in one place so a byte is noted before its results
   always @(posedge clock) begin : observe
      lcl_pkg::result_type got;
      if (!reset) begin
         if (req_valid && req_ready) board.note_byte(req_char_code, req_final_byte);
         if (rsp_valid && rsp_ready) begin
            got.token_kind  = rsp_token_kind;
            got.error_code  = rsp_error_code;
            got.start_pos   = rsp_start_pos;
            got.end_pos     = rsp_end_pos;
            got.last_result = rsp_last_result;
            board.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : result_side
      int unsigned stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // entered and left at a falling edge; valid stays up when the next byte has no gap
   task automatic send_byte(input logic [7:0] c, input logic fin);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= c;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_command();
      foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
      cmd_bytes.delete();
   endtask

   task automatic hold_off();
      req_valid <= 1'b0;
      while (board.expected_tokens.size() != 0) @(negedge clock);
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_space();
      int unsigned r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
   endfunction

   function automatic logic [7:0] pick_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? "A" + 8'(r) : "a" + 8'(r - 26);
   endfunction

   function automatic logic [7:0] pick_tail();
      case ($urandom_range(0, 3))
         0, 1: return pick_letter();
         2: return "0" + 8'($urandom_range(0, 9));
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] pick_trouble();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return "-";
         2: return ">";
         default: return "0" + 8'($urandom_range(0, 9));
      endcase
   endfunction

   // mostly well-formed commands; some get a bad byte, a few are pure noise
   function automatic void build_command();
      int unsigned n_tokens;
      int unsigned choice;
      logic        prev_word;
      logic        this_word;
      n_tokens  = $urandom_range(1, 6);
      prev_word = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat (n_tokens) begin
         choice    = $urandom_range(0, 7);
         this_word = (choice >= 4);
         // keep adjacent words apart so they do not merge
         if ((prev_word && this_word) || $urandom_range(0, 2) == 0)
            cmd_bytes.push_back(pick_space());
         case (choice)
            0: cmd_bytes.push_back("(");
            1: cmd_bytes.push_back(")");
            2: cmd_bytes.push_back(",");
            3: begin
               cmd_bytes.push_back("-");
               cmd_bytes.push_back(">");
            end
            4: cmd_bytes.push_back("1");
            default: begin
               cmd_bytes.push_back(pick_letter());
               repeat ($urandom_range(0, 4)) cmd_bytes.push_back(pick_tail());
            end
         endcase
         prev_word = this_word;
      end
      if ($urandom_range(0, 1) == 0) cmd_bytes.push_back(pick_space());
      if ($urandom_range(0, 3) == 0)
         cmd_bytes[$urandom_range(0, cmd_bytes.size() - 1)] = pick_trouble();
   endfunction

   initial begin : stimulus
      int unsigned goal;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every token kind, ending with symbol, rparen and close in one transfer
      add_text(" (a_9,1)->Z)");
      send_command();
      // lone minus on the last byte
      add_text("-");
      send_command();
      // pending one closed by the last byte
      add_text("1");
      send_command();
      // one followed by a symbol byte, rest of the command discarded
      add_text("1ax");
      send_command();
      add_text("5");
      send_command();
      // non-ascii inside a symbol
      add_text("a");
      cmd_bytes.push_back(8'hFF);
      send_command();
      add_text("1");
      cmd_bytes.push_back(8'h80);
      send_command();
      add_text("-");
      cmd_bytes.push_back(8'h80);
      send_command();
      // one token completed ahead of the gt error
      add_text("1>");
      send_command();
      cmd_bytes.push_back(8'h00);
      send_command();
      add_text("x");
      send_command();
      hold_off();

      goal = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < goal) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         build_command();
         send_command();
         if ($urandom_range(0, 5) == 0) hold_off();
      end
      hold_off();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.expected_tokens.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
